### sv/r10bu_pkg.sv
// Shared types, constants and the Bayer colour lookup for the RAW10 unpacker.
// Used by raw10_bayer_unpacker and its port checker; depends on nothing.
`default_nettype none

package r10bu_pkg;

	// Size limits and row alignment
	localparam int MAX_GROUPS  = 1024;
	localparam int MAX_ROWS    = 4096;
	localparam int ROW_ALIGN   = 8;
	localparam int GROUP_BYTES = 5;
	localparam int GROUP_PIX   = 4;

	// Derived widths
	localparam int GROUPS_W    = $clog2(MAX_GROUPS + 1);
	localparam int GROUP_IDX_W = $clog2(MAX_GROUPS);
	localparam int ROWS_W      = $clog2(MAX_ROWS + 1);
	localparam int ROW_IDX_W   = $clog2(MAX_ROWS);
	localparam int PAD_W       = $clog2(ROW_ALIGN + 1);
	localparam int PROD_W      = GROUPS_W + $clog2(GROUP_BYTES + 1);
	localparam int BCNT_W      = $clog2(GROUP_BYTES);

	// Fixed field widths
	localparam int BYTE_W  = 8;
	localparam int PIX_W   = 12;
	localparam int COORD_W = 12;
	localparam int CFG_W   = ROWS_W;
	localparam int ADDR_W  = 2;

	typedef logic [GROUPS_W-1:0]    groups_t;
	typedef logic [GROUP_IDX_W-1:0] group_idx_t;
	typedef logic [ROWS_W-1:0]      rows_t;
	typedef logic [ROW_IDX_W-1:0]   row_idx_t;
	typedef logic [PAD_W-1:0]       pad_t;
	typedef logic [PROD_W-1:0]      prod_t;
	typedef logic [BCNT_W-1:0]      bcnt_t;
	typedef logic [PIX_W-1:0]       pix_t;
	typedef logic [COORD_W-1:0]     coord_t;
	typedef logic [CFG_W-1:0]       cfg_data_t;
	typedef logic [ADDR_W-1:0]      cfg_addr_t;
	typedef logic [1:0]             colour_t;
	typedef logic [1:0]             pattern_t;

	// Register indexes
	localparam cfg_addr_t REG_GROUPS  = 2'd0;
	localparam cfg_addr_t REG_ROWS    = 2'd1;
	localparam cfg_addr_t REG_PATTERN = 2'd2;

	// Colour codes
	localparam colour_t COL_RED   = 2'd0;
	localparam colour_t COL_GREEN = 2'd1;
	localparam colour_t COL_BLUE  = 2'd2;

	// Pattern codes, named by the top-left 2x2 block
	localparam pattern_t PAT_RGGB = 2'd0;
	localparam pattern_t PAT_GRBG = 2'd1;
	localparam pattern_t PAT_BGGR = 2'd2;
	localparam pattern_t PAT_GBRG = 2'd3;

	// Colour of a pixel from the pattern and the row and column parity
	function automatic colour_t bayer_colour(input pattern_t pattern, input logic row_odd,
		input logic col_odd);
		colour_t c00;
		colour_t c01;
		colour_t c10;
		colour_t c11;
		c00 = COL_RED;
		c01 = COL_GREEN;
		c10 = COL_GREEN;
		c11 = COL_BLUE;
		case (pattern)
			PAT_RGGB: begin
				c00 = COL_RED;   c01 = COL_GREEN;
				c10 = COL_GREEN; c11 = COL_BLUE;
			end
			PAT_GRBG: begin
				c00 = COL_GREEN; c01 = COL_RED;
				c10 = COL_BLUE;  c11 = COL_GREEN;
			end
			PAT_BGGR: begin
				c00 = COL_BLUE;  c01 = COL_GREEN;
				c10 = COL_GREEN; c11 = COL_RED;
			end
			PAT_GBRG: begin
				c00 = COL_GREEN; c01 = COL_BLUE;
				c10 = COL_RED;   c11 = COL_GREEN;
			end
			default: begin
				c00 = COL_RED;   c01 = COL_GREEN;
				c10 = COL_GREEN; c11 = COL_BLUE;
			end
		endcase
		if (row_odd)
			return col_odd ? c11 : c10;
		return col_odd ? c01 : c00;
	endfunction

endpackage

`default_nettype wire

### sv/raw10_bayer_unpacker.sv
// Top level of the RAW10 packed Bayer stream unpacker.
// Depends on r10bu_pkg.
`default_nettype none

// The block takes one stream byte per cycle and gives one pixel per cycle while
// out_stall is low. Four bytes of a group are held; on the fifth byte the four
// pixels, with row, column and colour, are built in one pass and loaded into a
// four-entry result register, from which they are offered in column order, the
// first one in the cycle after the fifth byte. Row padding bytes are taken one
// per cycle with no result. A fifth byte is held off (in_stall) only while the
// previous group has not yet fully left the result register, so with a free
// output side the input never stalls: five bytes in, four pixels out.
module raw10_bayer_unpacker (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration writes
	input  wire logic                   cfg_write,
	input  wire r10bu_pkg::cfg_addr_t   cfg_addr,
	input  wire r10bu_pkg::cfg_data_t   cfg_data,
	// byte stream in
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [7:0]             raw_byte,
	// pixels out
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [11:0]                 pixel_value,
	output logic [11:0]                 pixel_row,
	output logic [11:0]                 pixel_column,
	output logic [1:0]                  colour,
	output logic                        group_end,
	output logic                        frame_end
);

	// Configuration registers
	r10bu_pkg::groups_t  groups_per_row_q;
	r10bu_pkg::rows_t    row_count_q;
	r10bu_pkg::pattern_t bayer_pattern_q;

	// Stream position
	logic [7:0]            held_q [r10bu_pkg::GROUP_PIX];
	r10bu_pkg::bcnt_t      byte_cnt_q;
	r10bu_pkg::group_idx_t group_q;
	r10bu_pkg::row_idx_t   row_q;
	r10bu_pkg::pad_t       pad_q;

	// Result register: one group of four pixels
	r10bu_pkg::pix_t       value_s1  [r10bu_pkg::GROUP_PIX];
	r10bu_pkg::colour_t    colour_s1 [r10bu_pkg::GROUP_PIX];
	r10bu_pkg::row_idx_t   row_s1;
	r10bu_pkg::group_idx_t group_s1;
	logic                  frame_end_s1;
	logic                  busy_q;
	logic [1:0]            pix_q;

	r10bu_pkg::groups_t    eff_groups;
	r10bu_pkg::rows_t      eff_rows;
	r10bu_pkg::prod_t      row_bytes;
	r10bu_pkg::pad_t       pad_calc;
	logic                  is_pad;
	logic                  is_last_byte;
	logic                  in_fire;
	logic                  out_fire;
	logic                  buf_free;
	logic                  emit;
	logic                  last_group;
	logic                  last_row;
	r10bu_pkg::pix_t       value_d  [r10bu_pkg::GROUP_PIX];
	r10bu_pkg::colour_t    colour_d [r10bu_pkg::GROUP_PIX];

	// Effective sizes: zero reads as one, oversize saturates
	always_comb begin
		if (groups_per_row_q == '0)
			eff_groups = r10bu_pkg::groups_t'(1);
		else if (groups_per_row_q > r10bu_pkg::groups_t'(r10bu_pkg::MAX_GROUPS))
			eff_groups = r10bu_pkg::groups_t'(r10bu_pkg::MAX_GROUPS);
		else
			eff_groups = groups_per_row_q;
		if (row_count_q == '0)
			eff_rows = r10bu_pkg::rows_t'(1);
		else if (row_count_q > r10bu_pkg::rows_t'(r10bu_pkg::MAX_ROWS))
			eff_rows = r10bu_pkg::rows_t'(r10bu_pkg::MAX_ROWS);
		else
			eff_rows = row_count_q;
	end

	// Padding after a row: a full alignment block when already aligned
	assign row_bytes = r10bu_pkg::prod_t'(eff_groups) *
		r10bu_pkg::prod_t'(r10bu_pkg::GROUP_BYTES);
	assign pad_calc = r10bu_pkg::pad_t'(r10bu_pkg::ROW_ALIGN) -
		r10bu_pkg::pad_t'(row_bytes % r10bu_pkg::ROW_ALIGN);

	// Handshake
	assign is_pad       = (pad_q != '0);
	assign is_last_byte = (byte_cnt_q == r10bu_pkg::bcnt_t'(r10bu_pkg::GROUP_BYTES - 1));
	assign out_valid    = busy_q;
	assign out_fire     = busy_q && !out_stall;
	assign buf_free     = !busy_q || (out_fire && (pix_q == 2'd3));
	assign in_stall     = !is_pad && is_last_byte && !buf_free;
	assign in_fire      = in_valid && !in_stall;
	assign emit         = in_fire && !is_pad && is_last_byte;

	assign last_group = (r10bu_pkg::groups_t'(group_q) + r10bu_pkg::groups_t'(1)) >= eff_groups;
	assign last_row   = (r10bu_pkg::rows_t'(row_q) + r10bu_pkg::rows_t'(1)) >= eff_rows;

	// Pixel build: high byte from the held bytes, low pair from the fifth byte
	always_comb begin
		for (int k = 0; k < r10bu_pkg::GROUP_PIX; k++) begin
			value_d[k]  = {held_q[k], raw_byte[2*k +: 2], 2'b00};
			colour_d[k] = r10bu_pkg::bayer_colour(bayer_pattern_q, row_q[0], k[0]);
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			groups_per_row_q <= r10bu_pkg::groups_t'(1);
			row_count_q      <= r10bu_pkg::rows_t'(1);
			bayer_pattern_q  <= r10bu_pkg::PAT_RGGB;
		end else if (cfg_write) begin
			case (cfg_addr)
				r10bu_pkg::REG_GROUPS:  groups_per_row_q <= cfg_data[r10bu_pkg::GROUPS_W-1:0];
				r10bu_pkg::REG_ROWS:    row_count_q      <= cfg_data;
				r10bu_pkg::REG_PATTERN: bayer_pattern_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Stream position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
			group_q    <= '0;
			row_q      <= '0;
			pad_q      <= '0;
		end else if (in_fire) begin
			if (is_pad) begin
				pad_q <= pad_q - r10bu_pkg::pad_t'(1);
			end else if (!is_last_byte) begin
				byte_cnt_q <= byte_cnt_q + r10bu_pkg::bcnt_t'(1);
			end else begin
				byte_cnt_q <= '0;
				if (last_group) begin
					group_q <= '0;
					pad_q   <= pad_calc;
					row_q   <= last_row ? '0 : row_q + r10bu_pkg::row_idx_t'(1);
				end else begin
					group_q <= group_q + r10bu_pkg::group_idx_t'(1);
				end
			end
		end
	end

	// Held high bytes
	always_ff @(posedge clk) begin
		if (in_fire && !is_pad && !is_last_byte)
			held_q[byte_cnt_q[1:0]] <= raw_byte;
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			value_s1     <= value_d;
			colour_s1    <= colour_d;
			row_s1       <= row_q;
			group_s1     <= group_q;
			frame_end_s1 <= last_group && last_row;
		end
	end

	// Result register drain control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pix_q  <= '0;
		end else if (emit) begin
			busy_q <= 1'b1;
			pix_q  <= '0;
		end else if (out_fire) begin
			if (pix_q == 2'd3)
				busy_q <= 1'b0;
			pix_q <= pix_q + 2'd1;
		end
	end

	// Output selection
	assign pixel_value  = value_s1[pix_q];
	assign pixel_row    = r10bu_pkg::coord_t'(row_s1);
	assign pixel_column = r10bu_pkg::coord_t'({group_s1, pix_q});
	assign colour       = colour_s1[pix_q];
	assign group_end    = (pix_q == 2'd3);
	assign frame_end    = (pix_q == 2'd3) && frame_end_s1;

endmodule

`default_nettype wire

### sv/r10bu_checker.sv
// Port-level checker for raw10_bayer_unpacker, bound to the top level.
// Depends on r10bu_pkg.
`default_nettype none

module r10bu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [11:0] pixel_value,
	input wire logic [11:0] pixel_column,
	input wire logic [1:0]  colour,
	input wire logic        group_end,
	input wire logic        frame_end
);

	// A stalled request stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// Pixels of one group are offered back to back in column order
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !group_end |=>
		out_valid && (pixel_column == 12'($past(pixel_column) + 12'd1)))
		else $error("group pixel missing or out of column order");

	// Frame end only on the last pixel of a group
	a_frame_group: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> group_end)
		else $error("frame_end without group_end");

	// Ten-bit data shifted up by two
	a_low_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pixel_value[1:0] == 2'b00)
		else $error("pixel_value low bits not zero");

	// Colour is red, green or blue
	a_colour: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (colour == r10bu_pkg::COL_RED) || (colour == r10bu_pkg::COL_GREEN) ||
		(colour == r10bu_pkg::COL_BLUE))
		else $error("invalid colour code");

endmodule

bind raw10_bayer_unpacker r10bu_checker u_r10bu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.pixel_value  (pixel_value),
	.pixel_column (pixel_column),
	.colour       (colour),
	.group_end    (group_end),
	.frame_end    (frame_end)
);

`default_nettype wire

### bench/tb_raw10_bayer_unpacker.sv
// Self-checking bench for raw10_bayer_unpacker: drives packed RAW10 bytes under random
// idling and back-pressure and checks every pixel against an in-bench unpacker.
// Depends on r10bu_pkg and raw10_bayer_unpacker.
`default_nettype none

module tb_raw10_bayer_unpacker;

	localparam int STALL_LIMIT = 2000;	// cycles with no request moving on either side
	localparam int LONG_HOLD   = 300;	// receiver hold-off that fills the block
	localparam int TAIL_CYCLES = 8;

	// One expected pixel
	typedef struct {
		r10bu_pkg::pix_t    value;
		r10bu_pkg::coord_t  row;
		r10bu_pkg::coord_t  col;
		r10bu_pkg::colour_t colour;
		logic               gend;
		logic               fend;
	} pixel_rec_t;

	// Directed stimulus row; vals holds the four pixels when typed is set
	typedef struct packed {
		logic [7:0]      data;
		logic            typed;
		logic [3:0][11:0] vals;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	r10bu_pkg::cfg_addr_t cfg_addr = r10bu_pkg::REG_GROUPS;
	r10bu_pkg::cfg_data_t cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [7:0]           raw_byte = 8'h00;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [11:0]          pixel_value;
	logic [11:0]          pixel_row;
	logic [11:0]          pixel_column;
	logic [1:0]           colour;
	logic                 group_end;
	logic                 frame_end;

	// Shadow registers and unpacker state
	r10bu_pkg::groups_t   cfg_groups = 11'd1;
	r10bu_pkg::rows_t     cfg_rows = 13'd1;
	r10bu_pkg::pattern_t  cfg_pattern = r10bu_pkg::PAT_RGGB;
	logic [7:0] held [4];
	int         byte_cnt = 0;
	int         grp_idx = 0;
	int         row_idx = 0;
	int         pad_left = 0;

	pixel_rec_t pending_pixels [$];
	pixel_rec_t popped;
	int         mismatches = 0;
	int         pixels_checked = 0;
	int         bytes_sent = 0;
	int         settings_used = 0;
	int         tx_idle_pct = 10;
	int         rx_idle_pct = 53;
	int         hold_requests = 0;
	int         hold_seen = 0;
	int         hold_left = 0;
	int         quiet_cycles = 0;

	// Reset frame geometry: one group, one row, three padding bytes per frame
	dir_row_t directed_rows [0:23] = '{
		'{8'hFF, 1'b0, 48'h0}, '{8'hFF, 1'b0, 48'h0}, '{8'hFF, 1'b0, 48'h0},
		'{8'hFF, 1'b0, 48'h0},
		'{8'hFF, 1'b1, {12'hFFC, 12'hFFC, 12'hFFC, 12'hFFC}},
		'{8'hA5, 1'b0, 48'h0}, '{8'h5A, 1'b0, 48'h0}, '{8'h3C, 1'b0, 48'h0},
		'{8'h00, 1'b0, 48'h0}, '{8'h00, 1'b0, 48'h0}, '{8'h00, 1'b0, 48'h0},
		'{8'h00, 1'b0, 48'h0},
		'{8'h00, 1'b1, {12'h000, 12'h000, 12'h000, 12'h000}},
		'{8'hFF, 1'b0, 48'h0}, '{8'hC3, 1'b0, 48'h0}, '{8'h81, 1'b0, 48'h0},
		'{8'h80, 1'b0, 48'h0}, '{8'h01, 1'b0, 48'h0}, '{8'h7F, 1'b0, 48'h0},
		'{8'hFE, 1'b0, 48'h0},
		// low pairs 3,2,1,0 from pixel 3 down to pixel 0
		'{8'hE4, 1'b1, {12'hFEC, 12'h7F8, 12'h014, 12'h800}},
		'{8'h00, 1'b0, 48'h0}, '{8'hFF, 1'b0, 48'h0}, '{8'h96, 1'b0, 48'h0}
	};

	raw10_bayer_unpacker DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.raw_byte     (raw_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_value  (pixel_value),
		.pixel_row    (pixel_row),
		.pixel_column (pixel_column),
		.colour       (colour),
		.group_end    (group_end),
		.frame_end    (frame_end)
	);

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what, input int want, input int got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
	endtask

	// Bayer colour: red sits at one corner of the 2x2 tile, blue at the opposite one
	function automatic r10bu_pkg::colour_t colour_at(input r10bu_pkg::pattern_t pat,
		input int row, input int col);
		logic red_r;
		logic red_c;
		red_r = 1'b0;
		red_c = 1'b0;
		case (pat)
			r10bu_pkg::PAT_RGGB: begin red_r = 1'b0; red_c = 1'b0; end
			r10bu_pkg::PAT_GRBG: begin red_r = 1'b0; red_c = 1'b1; end
			r10bu_pkg::PAT_BGGR: begin red_r = 1'b1; red_c = 1'b1; end
			r10bu_pkg::PAT_GBRG: begin red_r = 1'b1; red_c = 1'b0; end
			default:             begin red_r = 1'b0; red_c = 1'b0; end
		endcase
		if ((row[0] ^ col[0]) != (red_r ^ red_c))
			return r10bu_pkg::COL_GREEN;
		if (row[0] == red_r)
			return r10bu_pkg::COL_RED;
		return r10bu_pkg::COL_BLUE;
	endfunction

	// Unpacker: consume one accepted byte, queue the pixels it completes
	task automatic unpack_byte(input logic [7:0] b);
		int groups;
		int rows;
		int col;
		bit last_grp;
		bit last_row;
		logic [9:0] raw10;
		pixel_rec_t px;
		groups = (cfg_groups == 0) ? 1 : (cfg_groups > r10bu_pkg::MAX_GROUPS ?
			r10bu_pkg::MAX_GROUPS : cfg_groups);
		rows = (cfg_rows == 0) ? 1 : (cfg_rows > r10bu_pkg::MAX_ROWS ?
			r10bu_pkg::MAX_ROWS : cfg_rows);
		if (pad_left > 0) begin
			pad_left--;
			return;
		end
		if (byte_cnt < 4) begin
			held[byte_cnt] = b;
			byte_cnt++;
			return;
		end
		byte_cnt = 0;
		last_grp = (grp_idx + 1 >= groups);
		last_row = (row_idx + 1 >= rows);
		for (int k = 0; k < 4; k++) begin
			col = grp_idx * 4 + k;
			raw10 = {held[k], b[2*k +: 2]};
			px.value = {raw10, 2'b00};
			px.row = r10bu_pkg::coord_t'(row_idx);
			px.col = r10bu_pkg::coord_t'(col);
			px.colour = colour_at(cfg_pattern, row_idx, col);
			px.gend = (k == 3);
			px.fend = (k == 3) && last_grp && last_row;
			pending_pixels.push_back(px);
		end
		if (last_grp) begin
			grp_idx = 0;
			pad_left = r10bu_pkg::ROW_ALIGN -
				((groups * r10bu_pkg::GROUP_BYTES) % r10bu_pkg::ROW_ALIGN);
			row_idx = last_row ? 0 : row_idx + 1;
		end else begin
			grp_idx++;
		end
	endtask

	// Offer one byte request, idling cycle by cycle first, and wait for it to be taken
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		raw_byte <= b;
		do @(posedge clk); while (in_stall !== 1'b0);
		unpack_byte(b);
		bytes_sent++;
	endtask

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++)
			send_byte(8'($urandom_range(255)));
	endtask

	// Stop offering and let every queued pixel come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Write all three registers on back-to-back cycles; block must be idle
	task automatic configure(input int groups, input int rows,
		input r10bu_pkg::pattern_t pat);
		cfg_write <= 1'b1;
		cfg_addr <= r10bu_pkg::REG_GROUPS;
		cfg_data <= r10bu_pkg::cfg_data_t'(groups);
		@(posedge clk);
		cfg_addr <= r10bu_pkg::REG_ROWS;
		cfg_data <= r10bu_pkg::cfg_data_t'(rows);
		@(posedge clk);
		cfg_addr <= r10bu_pkg::REG_PATTERN;
		cfg_data <= r10bu_pkg::cfg_data_t'(pat);
		@(posedge clk);
		cfg_write <= 1'b0;
		cfg_groups = r10bu_pkg::groups_t'(groups);
		cfg_rows = r10bu_pkg::rows_t'(rows);
		cfg_pattern = pat;
		settings_used++;
	endtask

	// Receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Pixel checker
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_pixels.size() == 0) begin
				flag_mismatch("pixel with none pending", 0, pixel_value);
			end else begin
				popped = pending_pixels.pop_front();
				pixels_checked++;
				if (pixel_value !== popped.value)
					flag_mismatch("pixel_value", popped.value, pixel_value);
				if (pixel_row !== popped.row)
					flag_mismatch("pixel_row", popped.row, pixel_row);
				if (pixel_column !== popped.col)
					flag_mismatch("pixel_column", popped.col, pixel_column);
				if (colour !== popped.colour)
					flag_mismatch("colour", popped.colour, colour);
				if (group_end !== popped.gend)
					flag_mismatch("group_end", popped.gend, group_end);
				if (frame_end !== popped.fend)
					flag_mismatch("frame_end", popped.fend, frame_end);
			end
		end
	end

	// Watchdog on forward progress
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no request moved for %0d cycles", STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Stimulus
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at the reset geometry
		foreach (directed_rows[i]) begin
			send_byte(directed_rows[i].data);
			if (directed_rows[i].typed) begin
				for (int k = 0; k < 4; k++)
					if (pending_pixels[pending_pixels.size() - 4 + k].value
						!== directed_rows[i].vals[k])
						flag_mismatch("directed pixel_value", directed_rows[i].vals[k],
							pending_pixels[pending_pixels.size() - 4 + k].value);
			end
		end
		wait_drained();

		// Three groups: one padding byte after the first row
		configure(3, 2, r10bu_pkg::PAT_GRBG);
		send_random(16);
		wait_drained();

		// Receiver holds off long enough to back up the input; stop mid-padding
		configure(2, 3, r10bu_pkg::PAT_BGGR);
		hold_requests++;
		send_random(14);
		wait_drained();

		// Idling swapped; zero sizes act as one, taking over mid-padding
		tx_idle_pct = 53;
		rx_idle_pct = 10;
		configure(0, 0, r10bu_pkg::PAT_GBRG);
		send_random(16);
		wait_drained();

		// Oversize group and row counts saturate, stopping inside a group
		configure(2047, 8191, r10bu_pkg::PAT_RGGB);
		send_random(25);
		wait_drained();

		// No idling; shrink mid-frame: a group index already at or past the new size ends the row
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		configure(1, 2, r10bu_pkg::PAT_GRBG);
		send_random(13);
		wait_drained();

		if (pending_pixels.size() != 0)
			flag_mismatch("pixels never produced", 0, pending_pixels.size());
		$display("Sent %0d stream bytes under %0d register settings; checked %0d pixels,",
			bytes_sent, settings_used, pixels_checked);
		$display("including a long output hold-off, zero and oversize sizes and a shrink.");
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire

### raw10_bayer_unpacker.f
sv/r10bu_pkg.sv
sv/raw10_bayer_unpacker.sv
sv/r10bu_checker.sv
bench/tb_raw10_bayer_unpacker.sv
